// File: src/tsdm_pkg.sv
`timescale 1ns / 1ps

package tsdm_pkg;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CFG_CRUISE_THROTTLE = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_NEAR_DISTANCE   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_CROSS_HOLD      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_RING_HOLD       = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_SIGN_LOSS       = 3'd4;

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  localparam logic [1:0] COLOR_OTHER  = 2'd0;
  localparam logic [1:0] COLOR_RED    = 2'd1;
  localparam logic [1:0] COLOR_YELLOW = 2'd2;
  localparam logic [1:0] COLOR_GREEN  = 2'd3;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_CROSS = 2'd1;
  localparam logic [1:0] KIND_RING  = 2'd2;
  localparam logic [1:0] KIND_OTHER = 2'd3;

  localparam logic [7:0] SECS_MAX = 8'd255;

  typedef enum logic [3:0] {
    MODE_DRIVE        = 4'd0,
    MODE_CROSS_BEFORE = 4'd1,
    MODE_CROSS_NOW    = 4'd2,
    MODE_RING_BEFORE  = 4'd3,
    MODE_RING_NOW     = 4'd4,
    MODE_RED_BEFORE   = 4'd5,
    MODE_RED_NOW      = 4'd6,
    MODE_YEL_BEFORE   = 4'd7,
    MODE_YEL_NOW      = 4'd8,
    MODE_GRN_BEFORE   = 4'd9,
    MODE_GRN_NOW      = 4'd10
  } mode_t;

  typedef struct packed {
    logic        op;
    logic        light_seen;
    logic [1:0]  light_color;
    logic [15:0] light_range;
    logic        sign_seen;
    logic [1:0]  sign_kind;
    logic [15:0] sign_range;
  } item_t;

  typedef struct packed {
    logic [15:0] cruise_throttle;
    logic [15:0] near_distance;
    logic [7:0]  cross_hold_secs;
    logic [7:0]  ring_hold_secs;
    logic [7:0]  sign_loss_secs;
  } cfg_t;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] throttle;
    logic        light_active;
    logic        cross_hold_run;
    logic [7:0]  cross_hold_cnt;
    logic        ring_hold_run;
    logic [7:0]  ring_hold_cnt;
    logic        cross_miss_run;
    logic [7:0]  cross_miss_cnt;
    logic        ring_miss_run;
    logic [7:0]  ring_miss_cnt;
  } state_t;

  // handshake status between the input stage and the state stage
  typedef struct packed {
    logic valid;
    logic fire;
  } stage_ctl_t;

  function automatic logic [7:0] sat_inc(input logic [7:0] c);
    sat_inc = (c == SECS_MAX) ? SECS_MAX : c + 8'd1;
  endfunction

endpackage

// File: src/tsdm_in_stage.sv
`timescale 1ns / 1ps

module tsdm_in_stage import tsdm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  item_t      in_item,
  input  logic       advance,
  output item_t      item,
  output stage_ctl_t ctl
);

  logic  valid_r, valid_nxt;
  item_t item_r;
  logic  accept;

  assign in_stall = valid_r && !advance;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign item      = item_r;
  assign ctl.valid = valid_r;
  assign ctl.fire  = valid_r && advance;

endmodule

// File: src/tsdm_decide.sv
`timescale 1ns / 1ps

module tsdm_decide import tsdm_pkg::*; (
  input  item_t  item,
  input  cfg_t   cfg,
  input  state_t cur,
  output state_t nxt
);

  logic   near_light;
  logic   near_sign;
  logic   done;
  mode_t  m1;
  state_t n;

  assign near_light = item.light_range < cfg.near_distance;
  assign near_sign  = item.sign_range < cfg.near_distance;

  always_comb begin
    n    = cur;
    done = 1'b0;
    m1   = cur.mode;
    if (item.op == OP_TICK) begin
      if (cur.cross_hold_run) n.cross_hold_cnt = sat_inc(cur.cross_hold_cnt);
      if (cur.ring_hold_run)  n.ring_hold_cnt  = sat_inc(cur.ring_hold_cnt);
      if (cur.cross_miss_run) n.cross_miss_cnt = sat_inc(cur.cross_miss_cnt);
      if (cur.ring_miss_run)  n.ring_miss_cnt  = sat_inc(cur.ring_miss_cnt);
    end else begin
      if (item.light_seen) begin
        n.light_active = 1'b1;
        case (item.light_color)
          COLOR_RED:    n.mode = near_light ? MODE_RED_NOW : MODE_RED_BEFORE;
          COLOR_YELLOW: n.mode = near_light ? MODE_YEL_NOW : MODE_YEL_BEFORE;
          COLOR_GREEN:  n.mode = near_light ? MODE_GRN_NOW : MODE_GRN_BEFORE;
          default:      n.light_active = 1'b0;
        endcase
        // light modes reapply their throttle even when the color is unknown
        case (n.mode)
          MODE_RED_NOW, MODE_YEL_NOW: n.throttle = '0;
          MODE_RED_BEFORE, MODE_YEL_BEFORE, MODE_GRN_BEFORE, MODE_GRN_NOW:
            n.throttle = cfg.cruise_throttle;
          default: ;
        endcase
        done = n.light_active;
      end

      if (!done) begin
        if (item.sign_seen) begin
          case (n.mode)
            MODE_DRIVE: begin
              if (item.sign_kind == KIND_CROSS) begin
                m1 = MODE_CROSS_BEFORE;
              end else if (item.sign_kind == KIND_RING) begin
                m1 = MODE_RING_BEFORE;
              end else begin
                m1 = MODE_DRIVE;
              end
            end
            MODE_CROSS_BEFORE:
              m1 = (item.sign_kind == KIND_CROSS && near_sign) ? MODE_CROSS_NOW
                                                               : MODE_CROSS_BEFORE;
            MODE_RING_BEFORE:
              m1 = (item.sign_kind == KIND_RING && near_sign) ? MODE_RING_NOW
                                                              : MODE_RING_BEFORE;
            MODE_CROSS_NOW: m1 = MODE_CROSS_NOW;
            MODE_RING_NOW:  m1 = MODE_RING_NOW;
            default:        m1 = MODE_DRIVE;
          endcase
          n.mode = m1;

          case (m1)
            MODE_CROSS_BEFORE: begin
              if (item.sign_kind == KIND_CROSS) begin
                n.cross_miss_run = 1'b0;
              end else if (!n.cross_miss_run) begin
                n.cross_miss_run = 1'b1;
                n.cross_miss_cnt = '0;
              end else if (n.cross_miss_cnt > cfg.sign_loss_secs) begin
                n.cross_miss_run = 1'b0;
                n.mode           = MODE_DRIVE;
              end
              n.throttle = cfg.cruise_throttle;
            end
            MODE_CROSS_NOW: begin
              if (!n.cross_hold_run) begin
                n.cross_hold_run = 1'b1;
                n.cross_hold_cnt = '0;
                n.throttle       = {1'b0, cfg.cruise_throttle[15:1]};
              end else if (n.cross_hold_cnt >= cfg.cross_hold_secs) begin
                n.mode           = MODE_DRIVE;
                n.cross_hold_run = 1'b0;
              end
            end
            MODE_RING_BEFORE: begin
              if (item.sign_kind == KIND_RING) begin
                n.ring_miss_run = 1'b0;
              end else if (!n.ring_miss_run) begin
                n.ring_miss_run = 1'b1;
                n.ring_miss_cnt = '0;
              end else if (n.ring_miss_cnt > cfg.sign_loss_secs) begin
                n.ring_miss_run = 1'b0;
                n.mode          = MODE_DRIVE;
              end
              n.throttle = cfg.cruise_throttle;
            end
            MODE_RING_NOW: begin
              if (!n.ring_hold_run) begin
                n.ring_hold_run = 1'b1;
                n.ring_hold_cnt = '0;
                n.throttle      = cfg.cruise_throttle;
              end else if (n.ring_hold_cnt >= cfg.ring_hold_secs) begin
                n.mode          = MODE_DRIVE;
                n.ring_hold_run = 1'b0;
              end
            end
            default: n.throttle = cfg.cruise_throttle;
          endcase
        end else begin
          n.throttle = cfg.cruise_throttle;
        end
      end
    end
  end

  assign nxt = n;

endmodule

// File: src/traffic_sign_drive_mode_fsm.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   in_op, in_light_*, in_sign_*
// out      output     out_valid / out_stall out_mode, out_throttle
// cfg      input      cfg_we (no wait)      cfg_idx, cfg_wdata
//
// One transaction per cycle sustained while out_stall is low; the result passes
// through the input register, then the state register, and out_valid is raised
// when the state register is loaded.
// The state register doubles as the result register: it is loaded only when
// the previous result has been taken or is being taken in the same cycle.
// rst_n is synchronous: mode returns to driving, all timers stop, and the
// configuration registers take their defaults.
// A stalled output holds the input register, which then raises in_stall.

module traffic_sign_drive_mode_fsm import tsdm_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_op,
  input  logic                in_light_seen,
  input  logic [1:0]          in_light_color,
  input  logic [15:0]         in_light_range,
  input  logic                in_sign_seen,
  input  logic [1:0]          in_sign_kind,
  input  logic [15:0]         in_sign_range,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [3:0]          out_mode,
  output logic [15:0]         out_throttle,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_idx,
  input  logic [CfgDataW-1:0] cfg_wdata
);

  item_t      in_item;
  item_t      s1_item;
  stage_ctl_t s1_ctl;
  logic       advance;
  cfg_t       cfg_r;
  state_t     state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_item.op          = in_op;
  assign in_item.light_seen  = in_light_seen;
  assign in_item.light_color = in_light_color;
  assign in_item.light_range = in_light_range;
  assign in_item.sign_seen   = in_sign_seen;
  assign in_item.sign_kind   = in_sign_kind;
  assign in_item.sign_range  = in_sign_range;

  assign advance = !out_valid_r || !out_stall;

  tsdm_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .item     (s1_item),
    .ctl      (s1_ctl)
  );

  tsdm_decide u_decide (
    .item (s1_item),
    .cfg  (cfg_r),
    .cur  (state_r),
    .nxt  (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cruise_throttle <= 16'd0;
      cfg_r.near_distance   <= 16'd768;
      cfg_r.cross_hold_secs <= 8'd3;
      cfg_r.ring_hold_secs  <= 8'd5;
      cfg_r.sign_loss_secs  <= 8'd10;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_CRUISE_THROTTLE: cfg_r.cruise_throttle <= cfg_wdata;
        CFG_NEAR_DISTANCE:   cfg_r.near_distance   <= cfg_wdata;
        CFG_CROSS_HOLD:      cfg_r.cross_hold_secs <= cfg_wdata[7:0];
        CFG_RING_HOLD:       cfg_r.ring_hold_secs  <= cfg_wdata[7:0];
        CFG_SIGN_LOSS:       cfg_r.sign_loss_secs  <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_ctl.fire) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (s1_ctl.fire) begin
        state_r <= state_nxt;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_mode     = state_r.mode;
  assign out_throttle = state_r.throttle;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_ctl.valid)
    else $error("input stalled with an empty input register");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    s1_ctl.fire |=> out_valid)
    else $error("processed transaction produced no result");

  a_state_holds_while_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(state_r))
    else $error("state changed while the result was stalled");

  a_tick_keeps_mode: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_ctl.fire && s1_item.op == OP_TICK) |=>
      (state_r.mode == $past(state_r.mode) && state_r.throttle == $past(state_r.throttle)))
    else $error("tick changed mode or throttle");

  a_tick_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_ctl.fire && s1_item.op == OP_TICK && state_r.cross_miss_run) |=>
      state_r.cross_miss_cnt >= $past(state_r.cross_miss_cnt))
    else $error("sign loss count went down on a tick");

endmodule
